### src/slwrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window rate meter package
// Shared types and constants of the sliding-window rate meter.
// ----------------------------------------------------------------------------
package slwrm_pkg;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE   = 8'd1;

    localparam logic [10:0] WINDOW_RESET = 11'd1000;
    localparam logic [23:0] SCALE_RESET  = 24'd2048000;

    localparam logic [31:0] BUCKET_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] SAMPLE_MAX = 16'hFFFF;
    localparam logic [39:0] TOTAL_MAX  = 40'hFF_FFFF_FFFF;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ER_CHECK,
        ST_ER_RD,
        ST_ER_WR,
        ST_UP_ADDR,
        ST_UP_RD,
        ST_UP_WR,
        ST_Q_CHECK,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_ROUND,
        ST_RESULT
    } t_state;

endpackage

### src/sliding_window_rate_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-window rate meter
// Ring of per-tick buckets with running totals; answers rate queries.
// ----------------------------------------------------------------------------
// One word is handled at a time by a sequencer around a single bucket memory,
// one shared 20x24 multiplier and one shared subtractor. An update locates,
// reads and writes one bucket. When aged buckets must be erased first, a check
// comes before it and each erased bucket, at most window of them, is read and
// written back in turn. A query has that erase step too, then two multiply
// passes and a 64-step restoring division. An unknown kind goes straight to the
// result. After reset, after a clear word and after a write to window_ticks, a
// clearing pass walks the memory one entry a cycle, and no word is accepted
// meanwhile. A finished result sits in an output register so the next word
// can be taken while it waits; a result that finds the register still full
// holds the sequencer until the register is emptied.
module sliding_window_rate_meter #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [slwrm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slwrm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input words.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [63:0]                      i_s_axis_tdata, // amount[15:0], time_tick[63:16]
    input  logic [1:0]                       i_s_axis_tuser, // kind[1:0]
    // Result words.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [31:0]                      o_m_axis_tdata, // rate_value[31:0]
    output logic [1:0]                       o_m_axis_tuser  // accepted[0], rate_valid[1]
);
    import slwrm_pkg::*;

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int WW0 = $clog2(RING_DEPTH + 1);
    localparam int WW  = (WW0 > 11) ? WW0 : 11;

    t_state r_state, n_state;

    logic [10:0]   r_window, n_window;
    logic [23:0]   r_scale, n_scale;
    logic [AW-1:0] r_head_index, n_head_index;
    logic [47:0]   r_head_time, n_head_time;
    logic          r_set, n_set;
    logic [39:0]   r_total_amt, n_total_amt;
    logic [31:0]   r_total_smp, n_total_smp;
    logic [AW-1:0] r_clr_idx, n_clr_idx;
    logic          r_clr_res, n_clr_res;
    logic          r_out_valid, n_out_valid;

    logic [1:0]    r_kind, n_kind;
    logic [15:0]   r_amount, n_amount;
    logic [47:0]   r_now, n_now;
    logic [47:0]   r_new_head, n_new_head;
    logic [WW-1:0] r_steps, n_steps;
    logic [AW-1:0] r_idx, n_idx;
    logic [63:0]   r_prod, n_prod;
    logic [56:0]   r_rem, n_rem;
    logic [56:0]   r_div, n_div;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_res_acc, n_res_acc;
    logic          r_res_rv, n_res_rv;
    logic [31:0]   r_res_val, n_res_val;
    logic          r_out_acc, n_out_acc;
    logic          r_out_rv, n_out_rv;
    logic [31:0]   r_out_val, n_out_val;

    // Bucket memory: samples in the top 16 bits, byte sum in the low 32.
    logic [47:0]   mem [RING_DEPTH];
    logic [47:0]   r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [47:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [WW-1:0] eff_w;
    logic [47:0]   in_now;
    logic          erase_need;
    logic [19:0]   mul_a;
    logic [43:0]   mul_p;
    logic [47:0]   offset;
    logic [WW:0]   idx_sum;
    logic [57:0]   rem_s;
    logic          rem_ge;
    logic [39:0]   add_amt;
    logic [31:0]   room_b;
    logic [39:0]   room_t;
    logic          round_up;

    // Window clamped to 1..RING_DEPTH.
    always_comb begin
        eff_w = WW'(r_window);
        if (r_window == 11'd0) begin
            eff_w = WW'(1);
        end else if (WW'(r_window) > WW'(RING_DEPTH)) begin
            eff_w = WW'(RING_DEPTH);
        end
    end

    assign in_now     = i_s_axis_tdata[63:16];
    assign erase_need = r_set && ({1'b0, in_now} >= ({1'b0, r_head_time} + 49'(eff_w)));

    // Shared multiplier: low then high 20-bit half of the total.
    assign mul_a = (r_state == ST_MUL_LO) ? r_total_amt[19:0] : r_total_amt[39:20];
    assign mul_p = 44'(mul_a) * 44'(r_scale);

    // Shared subtractor of the restoring divider.
    assign rem_s  = {r_rem, r_prod[63]};
    assign rem_ge = rem_s >= {1'b0, r_div};

    assign offset   = r_set ? (r_now - r_head_time) : 48'd0;
    assign idx_sum  = (WW + 1)'(r_head_index) + (WW + 1)'(offset[WW-1:0]);
    assign round_up = {r_rem, 1'b0} >= {1'b0, r_div};

    // Saturating amount to add into the addressed bucket.
    always_comb begin
        room_b  = BUCKET_MAX - r_rd_data[31:0];
        room_t  = TOTAL_MAX - r_total_amt;
        add_amt = 40'(r_amount);
        if (40'(room_b) < add_amt) begin
            add_amt = 40'(room_b);
        end
        if (room_t < add_amt) begin
            add_amt = room_t;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_val;
    assign o_m_axis_tuser  = {r_out_rv, r_out_acc};

    // Sequencer: next state, datapath and memory controls.
    always_comb begin
        n_state      = r_state;
        n_window     = r_window;
        n_scale      = r_scale;
        n_head_index = r_head_index;
        n_head_time  = r_head_time;
        n_set        = r_set;
        n_total_amt  = r_total_amt;
        n_total_smp  = r_total_smp;
        n_clr_idx    = r_clr_idx;
        n_clr_res    = r_clr_res;
        n_out_valid  = r_out_valid & ~i_m_axis_tready;
        n_kind       = r_kind;
        n_amount     = r_amount;
        n_now        = r_now;
        n_new_head   = r_new_head;
        n_steps      = r_steps;
        n_idx        = r_idx;
        n_prod       = r_prod;
        n_rem        = r_rem;
        n_div        = r_div;
        n_cnt        = r_cnt;
        n_res_acc    = r_res_acc;
        n_res_rv     = r_res_rv;
        n_res_val    = r_res_val;
        n_out_acc    = r_out_acc;
        n_out_rv     = r_out_rv;
        n_out_val    = r_out_val;
        mem_we       = 1'b0;
        mem_waddr    = r_clr_idx;
        mem_wdata    = 48'd0;
        mem_raddr    = r_head_index;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_idx == AW'(RING_DEPTH - 1)) begin
                    n_state = r_clr_res ? ST_RESULT : ST_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind     = i_s_axis_tuser;
                    n_amount   = i_s_axis_tdata[15:0];
                    n_now      = in_now;
                    n_steps    = '0;
                    n_new_head = in_now - 48'(eff_w) + 48'd1;
                    n_res_acc  = 1'b0;
                    n_res_rv   = 1'b0;
                    n_res_val  = 32'd0;
                    unique case (i_s_axis_tuser)
                        KIND_UPDATE: begin
                            if (r_set && r_head_time > in_now) begin
                                n_state = ST_RESULT;
                            end else begin
                                n_state = erase_need ? ST_ER_CHECK : ST_UP_ADDR;
                            end
                        end
                        KIND_QUERY: begin
                            n_state = erase_need ? ST_ER_CHECK : ST_Q_CHECK;
                        end
                        KIND_CLEAR: begin
                            n_head_index = '0;
                            n_head_time  = 48'd0;
                            n_set        = 1'b0;
                            n_total_amt  = 40'd0;
                            n_total_smp  = 32'd0;
                            n_clr_idx    = '0;
                            n_clr_res    = 1'b1;
                            n_state      = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            // Erase aged buckets from the head, one at a time: check, read, write back.
            ST_ER_CHECK: begin
                if (r_total_smp != 32'd0 && r_head_time < r_new_head && r_steps < eff_w) begin
                    n_state = ST_ER_RD;
                end else begin
                    n_head_time = r_new_head;
                    n_state     = (r_kind == KIND_UPDATE) ? ST_UP_ADDR : ST_Q_CHECK;
                end
            end
            ST_ER_RD: begin
                n_state = ST_ER_WR;
            end
            ST_ER_WR: begin
                mem_we       = 1'b1;
                mem_waddr    = r_head_index;
                n_total_smp  = r_total_smp - 32'(r_rd_data[47:32]);
                n_total_amt  = r_total_amt - 40'(r_rd_data[31:0]);
                n_head_index = (WW'(r_head_index) + WW'(1) >= eff_w) ? '0
                                                                    : r_head_index + 1'b1;
                n_head_time  = r_head_time + 48'd1;
                n_steps      = r_steps + 1'b1;
                n_state      = ST_ER_CHECK;
            end
            // Locate the bucket of the update's timestamp.
            ST_UP_ADDR: begin
                if (!r_set) begin
                    n_head_time = r_now;
                    n_set       = 1'b1;
                end
                if (idx_sum >= (WW + 1)'(eff_w)) begin
                    n_idx = AW'(idx_sum - (WW + 1)'(eff_w));
                end else begin
                    n_idx = AW'(idx_sum);
                end
                n_state = ST_UP_RD;
            end
            ST_UP_RD: begin
                mem_raddr = r_idx;
                n_state   = ST_UP_WR;
            end
            ST_UP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata[31:0]  = r_rd_data[31:0] + add_amt[31:0];
                mem_wdata[47:32] = r_rd_data[47:32];
                n_total_amt = r_total_amt + add_amt;
                if (r_rd_data[47:32] != SAMPLE_MAX) begin
                    mem_wdata[47:32] = r_rd_data[47:32] + 16'd1;
                    n_total_smp      = r_total_smp + 32'd1;
                end
                n_res_acc = 1'b1;
                n_state   = ST_RESULT;
            end
            // Query: check, then total * scale / (active * 256).
            ST_Q_CHECK: begin
                if (!r_set || r_total_smp == 32'd0 || r_now <= r_head_time) begin
                    n_state = ST_RESULT;
                end else begin
                    n_div   = {49'(r_now - r_head_time) + 49'd1, 8'd0};
                    n_state = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                n_prod  = 64'(mul_p);
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                n_prod  = r_prod + {mul_p, 20'd0};
                n_rem   = 57'd0;
                n_cnt   = 6'd0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem  = rem_ge ? 57'(rem_s - {1'b0, r_div}) : rem_s[56:0];
                n_prod = {r_prod[62:0], rem_ge};
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_state = ST_ROUND;
                end
            end
            // Round half up, then saturate to 32 bits.
            ST_ROUND: begin
                n_res_rv = 1'b1;
                if (r_prod[63:32] != 32'd0 || (r_prod[31:0] == 32'hFFFF_FFFF && round_up)) begin
                    n_res_val = 32'hFFFF_FFFF;
                end else begin
                    n_res_val = r_prod[31:0] + 32'(round_up);
                end
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_res_acc;
                    n_out_rv    = r_res_rv;
                    n_out_val   = r_res_val;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Configuration writes; a window write restarts the meter.
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_TICKS: begin
                    n_window     = i_cfg_data[10:0];
                    n_head_index = '0;
                    n_head_time  = 48'd0;
                    n_set        = 1'b0;
                    n_total_amt  = 40'd0;
                    n_total_smp  = 32'd0;
                    n_clr_idx    = '0;
                    n_clr_res    = 1'b0;
                    n_state      = ST_CLEAR;
                end
                CFG_RATE_SCALE: begin
                    n_scale = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_window     <= WINDOW_RESET;
            r_scale      <= SCALE_RESET;
            r_head_index <= '0;
            r_head_time  <= 48'd0;
            r_set        <= 1'b0;
            r_total_amt  <= 40'd0;
            r_total_smp  <= 32'd0;
            r_clr_idx    <= '0;
            r_clr_res    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_window     <= n_window;
            r_scale      <= n_scale;
            r_head_index <= n_head_index;
            r_head_time  <= n_head_time;
            r_set        <= n_set;
            r_total_amt  <= n_total_amt;
            r_total_smp  <= n_total_smp;
            r_clr_idx    <= n_clr_idx;
            r_clr_res    <= n_clr_res;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_amount   <= n_amount;
        r_now      <= n_now;
        r_new_head <= n_new_head;
        r_steps    <= n_steps;
        r_idx      <= n_idx;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_cnt      <= n_cnt;
        r_res_acc  <= n_res_acc;
        r_res_rv   <= n_res_rv;
        r_res_val  <= n_res_val;
        r_out_acc  <= n_out_acc;
        r_out_rv   <= n_out_rv;
        r_out_val  <= n_out_val;
    end

    // Bucket memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    // The totals stay the sum of the buckets: no samples means no amount.
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_total_smp == 32'd0) |-> (r_total_amt == 40'd0))
        else $error("amount left with no samples");

    // The divider remainder stays below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_div))
        else $error("divider remainder out of range");

    // The head slot lies inside the current window whenever the sequencer is idle.
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (WW'(r_head_index) < eff_w))
        else $error("head index outside window");

endmodule
